@@ hw/rtl/dibuf_pkg.sv @@
// Package for the dense interval start buffer.
// Holds operation and status codes, field widths and the word structs.
// No dependencies.
`timescale 1ns / 1ps

package dibuf_pkg;

  localparam int ID_W    = 31;
  localparam int START_W = 32;
  localparam int LIVE_W  = 11;

  // operation codes
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_QUERY     = 3'd2;
  localparam logic [2:0] OP_QUERY_ALL = 3'd3;
  localparam logic [2:0] OP_COUNT     = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // stored value of a removed slot
  localparam logic [START_W-1:0] REMOVED_MARK = '1;

  // command word handed from the top level to the sequencer
  typedef struct packed {
    logic [2:0]         op;
    logic [ID_W-1:0]    record_id;
    logic [ID_W-1:0]    start_time;
    logic signed [31:0] query_end;
  } cmd_t;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic signed [START_W-1:0] removed_start;
    logic [ID_W-1:0]           xor_of_ids;
    logic [LIVE_W-1:0]         live_count;
    logic [1:0]                status;
  } res_t;

endpackage

@@ hw/rtl/dibuf_ifs.sv @@
// Channel interfaces of the dense interval start buffer.
// Depends on dibuf_pkg for field widths.
`timescale 1ns / 1ps

interface dibuf_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     op;
  logic [dibuf_pkg::ID_W-1:0]     record_id;
  logic [dibuf_pkg::ID_W-1:0]     start_time;
  logic signed [31:0]             query_end;

  modport source (output valid, output op, output record_id, output start_time,
                  output query_end, input ready);
  modport sink   (input valid, input op, input record_id, input start_time,
                  input query_end, output ready);
endinterface

interface dibuf_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dibuf_pkg::START_W-1:0] removed_start;
  logic [dibuf_pkg::ID_W-1:0]         xor_of_ids;
  logic [dibuf_pkg::LIVE_W-1:0]       live_count;
  logic [1:0]                         status;

  modport source (output valid, output removed_start, output xor_of_ids,
                  output live_count, output status, input ready);
  modport sink   (input valid, input removed_start, input xor_of_ids,
                  input live_count, input status, output ready);
endinterface

@@ hw/rtl/dense_interval_start_buffer.sv @@
// Dense interval start buffer: one item at a time, the state held in a
// CAPACITY-entry start-time memory with registered read data. Insert and
// count go straight to the result; remove reads the slot, then writes the
// removed mark unless it is already there. The two queries read one slot
// of the memory per cycle, up to the fill count; the range query ends
// early at the first slot later than its end.
// The memory needs no clearing pass after reset: only filled slots are read.
// A result waits in the output register while the next word is taken.
// Depends on dibuf_pkg, dibuf_ifs and dibuf_seq.
`timescale 1ns / 1ps

module dense_interval_start_buffer #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  dibuf_cmd_if.sink   cmd,
  dibuf_rsp_if.source rsp
);

  dibuf_pkg::cmd_t cmd_word;
  dibuf_pkg::res_t res_word;
  dibuf_pkg::res_t out_q;
  logic            idle;
  logic            room;
  logic            done;
  logic            go;

  // input side
  always_comb begin
    cmd.ready           = idle;
    go                  = cmd.valid && idle;
    cmd_word.op         = cmd.op;
    cmd_word.record_id  = cmd.record_id;
    cmd_word.start_time = cmd.start_time;
    cmd_word.query_end  = cmd.query_end;
    room                = !rsp.valid || rsp.ready;
  end

  dibuf_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .cmd_word (cmd_word),
    .idle     (idle),
    .room     (room),
    .done     (done),
    .res_word (res_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_q <= res_word;
    end
  end

  assign rsp.removed_start = out_q.removed_start;
  assign rsp.xor_of_ids    = out_q.xor_of_ids;
  assign rsp.live_count    = out_q.live_count;
  assign rsp.status        = out_q.status;

endmodule

@@ hw/rtl/dibuf_mem.sv @@
// Start-time memory: one write port, one read port, registered read data.
// Depends on dibuf_pkg for the word width.
`timescale 1ns / 1ps

module dibuf_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [dibuf_pkg::START_W-1:0]    wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic [dibuf_pkg::START_W-1:0]    rd_data
);

  logic [dibuf_pkg::START_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/dibuf_seq.sv @@
// Sequencer of the dense interval start buffer: fill count, minimum id,
// live counter, remove read-modify-write and the slot scan of the queries.
// Depends on dibuf_pkg and dibuf_mem.
`timescale 1ns / 1ps

module dibuf_seq #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  dibuf_pkg::cmd_t  cmd_word,
  output logic             idle,
  input  logic             room,
  output logic             done,
  output dibuf_pkg::res_t  res_word
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int IW = dibuf_pkg::ID_W;
  localparam int SW = dibuf_pkg::START_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RMRD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state;
  dibuf_pkg::cmd_t      cmd_q;
  logic [FW-1:0]        fill;
  logic [IW-1:0]        min_id;
  logic [FW-1:0]        live;
  logic [FW-1:0]        idx;
  logic [FW-1:0]        idx_d;
  logic                 pend;
  logic [IW-1:0]        acc;
  logic [AW-1:0]        slot_q;
  logic [SW-1:0]        res_removed;
  logic [1:0]           res_status;

  logic                 full;
  logic [IW-1:0]        diff;
  logic                 rm_ok;
  logic                 issue;
  logic                 stop;
  logic [IW-1:0]        scan_id;
  logic [31:0]          live_wide;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SW-1:0]        rd_data;

  // status decode of the latched command
  always_comb begin
    full    = (fill == FW'(CAPACITY));
    diff    = cmd_q.record_id - min_id;
    rm_ok   = (cmd_q.record_id >= min_id) && (diff < {{(IW-FW){1'b0}}, fill});
    issue   = (idx < fill);
    stop    = (cmd_q.op == dibuf_pkg::OP_QUERY) &&
              ($signed(rd_data) > cmd_q.query_end);
    scan_id = {{(IW-FW){1'b0}}, idx_d} + min_id;
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = {1'b0, cmd_q.start_time};
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    if (state == S_EXEC) begin
      wr_en   = (cmd_q.op == dibuf_pkg::OP_INSERT) && !full;
      rd_en   = (cmd_q.op == dibuf_pkg::OP_REMOVE) && rm_ok;
      rd_addr = diff[AW-1:0];
    end else if (state == S_RMRD) begin
      wr_en   = (rd_data != dibuf_pkg::REMOVED_MARK);
      wr_addr = slot_q;
      wr_data = dibuf_pkg::REMOVED_MARK;
    end else if (state == S_SCAN) begin
      rd_en   = issue;
    end
  end

  dibuf_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      min_id <= '1;
      live   <= '0;
      pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            cmd_q <= cmd_word;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc         <= '0;
          res_removed <= '0;
          res_status  <= dibuf_pkg::ST_OK;
          slot_q      <= diff[AW-1:0];
          state       <= S_DONE;
          unique case (cmd_q.op)
            dibuf_pkg::OP_INSERT: begin
              if (full) begin
                res_status <= dibuf_pkg::ST_FULL;
              end else begin
                fill <= fill + FW'(1);
                live <= live + FW'(1);
                if (cmd_q.record_id < min_id) begin
                  min_id <= cmd_q.record_id;
                end
              end
            end
            dibuf_pkg::OP_REMOVE: begin
              if (rm_ok) begin
                state <= S_RMRD;
              end else begin
                res_status <= dibuf_pkg::ST_RANGE;
              end
            end
            dibuf_pkg::OP_QUERY, dibuf_pkg::OP_QUERY_ALL: begin
              idx   <= '0;
              pend  <= 1'b0;
              state <= S_SCAN;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RMRD: begin
          res_removed <= rd_data;
          if (rd_data != dibuf_pkg::REMOVED_MARK) begin
            live <= live - FW'(1);
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // one slot read issued and one slot checked per cycle
          pend  <= issue;
          idx_d <= idx;
          if (issue) begin
            idx <= idx + FW'(1);
          end
          if (pend) begin
            if (stop) begin
              pend  <= 1'b0;
              state <= S_DONE;
            end else if (rd_data != dibuf_pkg::REMOVED_MARK) begin
              acc <= acc ^ scan_id;
            end
          end else if (!issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    live_wide              = 32'(live);
    idle                   = (state == S_IDLE);
    done                   = (state == S_DONE) && room;
    res_word.removed_start = res_removed;
    res_word.xor_of_ids    = acc;
    res_word.live_count    = live_wide[dibuf_pkg::LIVE_W-1:0];
    res_word.status        = res_status;
  end

endmodule

@@ tb/tb_dense_interval_start_buffer.sv @@
// Testbench for the dense interval start buffer: a directed opening and random traffic
// with stalls on both channels, checked by a scoreboard.
// Depends on dibuf_pkg, dibuf_ifs and the dense_interval_start_buffer top level.
`timescale 1ns / 1ps

module tb_dense_interval_start_buffer;

  localparam int CAPACITY = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = CAPACITY + 16;
  localparam int RANDOM_WORDS = 555;
  localparam longint CYCLE_LIMIT = 7000000;

  // op codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam logic [dibuf_pkg::ID_W-1:0] ID_MAX = '1;
  localparam logic signed [31:0] QEND_MIN = 32'sh80000000;
  localparam logic signed [31:0] QEND_MAX = 32'sh7FFFFFFF;

  // start table predictor and queue of expected result words
  class interval_scoreboard;
    logic [dibuf_pkg::START_W-1:0] slot_start [CAPACITY];
    int unsigned fill;
    logic [dibuf_pkg::ID_W-1:0] min_id;
    int unsigned live;
    dibuf_pkg::res_t expected_q[$];
    int errors;

    function new();
      fill = 0;
      min_id = '1;
      live = 0;
      errors = 0;
    endfunction

    // record id of a slot, wrapping at 31 bits
    function logic [dibuf_pkg::ID_W-1:0] id_of_slot(int unsigned slot);
      logic [31:0] sum;
      sum = slot + {1'b0, min_id};
      return sum[dibuf_pkg::ID_W-1:0];
    endfunction

    function void note_input(dibuf_pkg::cmd_t w);
      dibuf_pkg::res_t r;
      logic [31:0] offset;
      int unsigned i;
      r = '0;
      case (w.op)
        dibuf_pkg::OP_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = dibuf_pkg::ST_FULL;
          end else begin
            slot_start[fill] = {1'b0, w.start_time};
            fill++;
            live++;
            if (w.record_id < min_id) min_id = w.record_id;
          end
        end
        dibuf_pkg::OP_REMOVE: begin
          offset = {1'b0, w.record_id} - {1'b0, min_id};
          if (w.record_id < min_id || offset >= fill) begin
            r.status = dibuf_pkg::ST_RANGE;
          end else begin
            r.removed_start = slot_start[offset];
            if (slot_start[offset] != dibuf_pkg::REMOVED_MARK) begin
              slot_start[offset] = dibuf_pkg::REMOVED_MARK;
              live--;
            end
          end
        end
        // scan stops at the first stored value past the end, removed marks included
        dibuf_pkg::OP_QUERY: begin
          for (i = 0; i < fill; i++) begin
            if ($signed(slot_start[i]) > $signed(w.query_end)) break;
            if (slot_start[i] != dibuf_pkg::REMOVED_MARK) r.xor_of_ids ^= id_of_slot(i);
          end
        end
        dibuf_pkg::OP_QUERY_ALL: begin
          for (i = 0; i < fill; i++) begin
            if (slot_start[i] != dibuf_pkg::REMOVED_MARK) r.xor_of_ids ^= id_of_slot(i);
          end
        end
        default: ;
      endcase
      r.live_count = live[dibuf_pkg::LIVE_W-1:0];
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(dibuf_pkg::res_t got);
      dibuf_pkg::res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("removed_start", want.removed_start, got.removed_start);
      compare_field("xor_of_ids", want.xor_of_ids, got.xor_of_ids);
      compare_field("live_count", want.live_count, got.live_count);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit quiet = 1'b0;
  bit hold_rsp = 1'b0;
  logic [dibuf_pkg::ID_W-1:0] last_start = '0;
  longint cycles = 0;

  dibuf_cmd_if cmd();
  dibuf_rsp_if rsp();

  interval_scoreboard sb = new();

  dense_interval_start_buffer #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dense_interval_start_buffer: done, errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    dibuf_pkg::res_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.removed_start = rsp.removed_start;
      got.xor_of_ids = rsp.xor_of_ids;
      got.live_count = rsp.live_count;
      got.status = rsp.status;
      sb.check_result(got);
    end
  end

  // idle length: mostly short, a few long, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // random 31-bit value
  function automatic logic [dibuf_pkg::ID_W-1:0] rand_id();
    logic [31:0] v;
    v = $urandom;
    return v[dibuf_pkg::ID_W-1:0];
  endfunction

  function automatic dibuf_pkg::cmd_t make_word(logic [2:0] op,
                                                logic [dibuf_pkg::ID_W-1:0] id,
                                                logic [dibuf_pkg::ID_W-1:0] start,
                                                logic signed [31:0] qend);
    dibuf_pkg::cmd_t w;
    w.op = op;
    w.record_id = id;
    w.start_time = start;
    w.query_end = qend;
    return w;
  endfunction

  // insert id: mostly at or above the minimum, some just below, a few anywhere
  function automatic logic [dibuf_pkg::ID_W-1:0] insert_id();
    int r;
    logic [dibuf_pkg::ID_W-1:0] low;
    logic [31:0] pick;
    r = $urandom_range(0, 99);
    low = sb.min_id;
    if (r < 50) begin
      pick = $urandom_range(ID_MAX, low);
      return pick[dibuf_pkg::ID_W-1:0];
    end
    if (r < 85) begin
      pick = (low > 31'd4) ? ({1'b0, low} - $urandom_range(0, 4)) : 32'd0;
      return pick[dibuf_pkg::ID_W-1:0];
    end
    return rand_id();
  endfunction

  // start times in rising runs with random jumps
  function automatic logic [dibuf_pkg::ID_W-1:0] next_start();
    logic [31:0] step;
    if ($urandom_range(0, 9) < 6) begin
      if (last_start < ID_MAX - 31'd64) step = {1'b0, last_start} + $urandom_range(0, 50);
      else step = $urandom_range(0, 1000);
    end else begin
      step = $urandom;
    end
    last_start = step[dibuf_pkg::ID_W-1:0];
    return last_start;
  endfunction

  // query end near stored starts, at the extremes, or anywhere
  function automatic logic signed [31:0] pick_query_end();
    int r;
    int unsigned slot;
    logic [31:0] near;
    r = $urandom_range(0, 99);
    if (r < 40 && sb.fill > 0) begin
      slot = $urandom_range(sb.fill - 1, 0);
      near = sb.slot_start[slot] + $urandom_range(0, 2) - 32'd1;
      return $signed(near);
    end
    if (r < 55) return $signed($urandom);
    if (r < 65) return -32'sd1;
    if (r < 72) return -32'sd2;
    if (r < 77) return QEND_MIN;
    if (r < 85) return QEND_MAX;
    return $signed($urandom_range(0, 2000));
  endfunction

  function automatic dibuf_pkg::cmd_t random_word();
    dibuf_pkg::cmd_t w;
    int r;
    logic [31:0] target;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    w = make_word(dibuf_pkg::OP_COUNT, rand_id(), rand_id(), $signed($urandom));
    if (r < 38) begin
      w.op = dibuf_pkg::OP_INSERT;
      w.record_id = insert_id();
      w.start_time = next_start();
    end else if (r < 68) begin
      // removes mostly hit filled slots, the rest land just past the end or anywhere
      w.op = dibuf_pkg::OP_REMOVE;
      if (sb.fill > 0 && $urandom_range(0, 3) != 0) begin
        target = {1'b0, sb.min_id} + $urandom_range(sb.fill - 1, 0);
        if (target <= {1'b0, ID_MAX}) w.record_id = target[dibuf_pkg::ID_W-1:0];
      end else if ($urandom_range(0, 1) == 0) begin
        target = {1'b0, sb.min_id} + sb.fill;
        if (target <= {1'b0, ID_MAX}) w.record_id = target[dibuf_pkg::ID_W-1:0];
      end
    end else if (r < 80) begin
      w.op = dibuf_pkg::OP_QUERY;
      w.query_end = pick_query_end();
    end else if (r < 88) begin
      w.op = dibuf_pkg::OP_QUERY_ALL;
    end else if (r >= 96) begin
      raw = {29'd0, OP_SPARE5} + $urandom_range(0, 2);
      w.op = raw[2:0];
    end
    return w;
  endfunction

  // offer one word after a random gap and wait for the handshake
  task automatic send_word(input dibuf_pkg::cmd_t w);
    int gap;
    logic [31:0] raw;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      raw = $urandom;
      cmd.valid = 1'b0;
      cmd.op = raw[2:0];
      cmd.record_id = rand_id();
      cmd.start_time = rand_id();
      cmd.query_end = $signed($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd.op = w.op;
    cmd.record_id = w.record_id;
    cmd.start_time = w.start_time;
    cmd.query_end = w.query_end;
    cmd.valid = 1'b1;
    do @(posedge clk); while (!cmd.ready);
    sb.note_input(w);
  endtask

  // result side back-pressure, with one long hold-off on request
  initial begin
    int run;
    int stall;
    rsp.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_rsp) begin
        @(negedge clk);
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_rsp = 1'b0;
      end
      run = quiet ? 40 : $urandom_range(1, 12);
      @(negedge clk);
      rsp.ready = 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        rsp.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int n;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.op = dibuf_pkg::OP_COUNT;
    cmd.record_id = '0;
    cmd.start_time = '0;
    cmd.query_end = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store
    send_word(make_word(dibuf_pkg::OP_COUNT, '0, '0, '0));
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, '0));
    send_word(make_word(dibuf_pkg::OP_QUERY_ALL, '0, '0, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, ID_MAX, '0, '0));
    // ids near the top so slot ids wrap past 2^31
    send_word(make_word(dibuf_pkg::OP_INSERT, ID_MAX, '0, '0));
    send_word(make_word(dibuf_pkg::OP_INSERT, ID_MAX, ID_MAX, '0));
    send_word(make_word(dibuf_pkg::OP_INSERT, ID_MAX - 31'd1, 31'd5, '0));
    send_word(make_word(dibuf_pkg::OP_QUERY_ALL, '0, '0, '0));
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, QEND_MAX));
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, 32'sd0));
    // removes: live slot, same slot again, below the minimum
    send_word(make_word(dibuf_pkg::OP_REMOVE, ID_MAX, '0, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, ID_MAX, '0, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, 31'h12345, '0, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, ID_MAX - 31'd1, '0, '0));
    // removed marks in the range scan
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, -32'sd2));
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, -32'sd1));
    send_word(make_word(dibuf_pkg::OP_QUERY, '0, '0, QEND_MIN));
    send_word(make_word(dibuf_pkg::OP_INSERT, '0, 31'h2AAAAAAA, '0));
    send_word(make_word(dibuf_pkg::OP_INSERT, 31'h55555555, 31'h55555555, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, '0, '0, '0));
    send_word(make_word(dibuf_pkg::OP_REMOVE, 31'd5, '0, '0));
    send_word(make_word(OP_SPARE5, ID_MAX, ID_MAX, QEND_MIN));
    send_word(make_word(OP_SPARE6, 31'h2AAAAAAA, 31'h55555555, QEND_MAX));
    send_word(make_word(OP_SPARE7, '0, '0, -32'sd1));
    send_word(make_word(dibuf_pkg::OP_QUERY_ALL, '0, '0, '0));

    // random traffic, with a long result hold-off at the start
    hold_rsp = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 150 && n < 210);
      send_word(random_word());
    end
    quiet = 1'b0;

    @(negedge clk);
    cmd.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_dense_interval_start_buffer: done, clean");
    end else begin
      $display("tb_dense_interval_start_buffer: done, errors");
    end
    $finish;
  end

endmodule
